/* design/lfr_pkg.sv */
// ============================================================================
// lfr_pkg
// Shared constants, codes and control types of the LRU frame replacer.
// ============================================================================
package lfr_pkg;

    localparam int FRAMES = 64;
    localparam int IDX_W  = $clog2(FRAMES);
    localparam int LEN_W  = $clog2(FRAMES + 1);
    localparam int FID_W  = 6;
    localparam int CMD_W  = 2;
    localparam int CNT_W  = 7;

    localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PIN    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNPIN  = 2'd2;

    localparam logic [LEN_W-1:0] CAP_RESET = LEN_W'(FRAMES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_TAIL,
        ST_UPDATE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture the accepted item
        logic issue_read;  // read next list entry
        logic update;      // commit marks, length, count and result
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_scan;   // item must walk the recency list
        logic scan_last;   // read address is the last list entry
    } t_dp_stat;

endpackage

/* design/lfr_ram.sv */
// ============================================================================
// lfr_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module lfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/lfr_ctrl.sv */
// ============================================================================
// lfr_ctrl
// Sequencer: accept, decode, list walk, commit, and output valid.
// ============================================================================
module lfr_ctrl
    import lfr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_ctl_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   can_commit;

    assign can_commit = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = i_stat.need_scan ? ST_READ : ST_UPDATE;
            end
            ST_READ: begin
                if (i_stat.scan_last) begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (can_commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_READ: begin
                o_cmd.issue_read = 1'b1;
            end
            ST_UPDATE: begin
                o_cmd.update = can_commit;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (o_cmd.update) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* design/lfr_datapath.sv */
// ============================================================================
// lfr_datapath
// Recency list RAM, frame marks, counters and the result register.
// ============================================================================
module lfr_datapath
    import lfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctl_cmd         i_cmd,
    output t_dp_stat         o_stat,
    input  logic [CMD_W-1:0] i_command,
    input  logic [FID_W-1:0] i_frame_num,
    input  logic [LEN_W-1:0] i_capacity,
    output logic             o_victim_valid,
    output logic [FID_W-1:0] o_victim_frame,
    output logic [CNT_W-1:0] o_evictable_count
);

    logic [CMD_W-1:0]  r_cmd;
    logic [FID_W-1:0]  r_fid;
    logic [IDX_W-1:0]  r_rd_addr;
    logic              r_pend;
    logic [IDX_W-1:0]  r_pend_idx;
    logic              r_found;
    logic [IDX_W-1:0]  r_vframe;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [FRAMES-1:0] r_tracked, n_tracked;
    logic [FRAMES-1:0] r_evict, n_evict;
    logic [CNT_W-1:0]  r_total, n_total;
    logic              r_o_vvalid;
    logic [FID_W-1:0]  r_o_vframe;
    logic [CNT_W-1:0]  r_o_count;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [IDX_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]  rd_data;

    logic              fid_ok;
    logic [IDX_W-1:0]  fid_idx;
    logic              trk;
    logic              ev;
    logic              match;
    logic              n_vvalid;

    lfr_ram #(
        .WIDTH (IDX_W),
        .DEPTH (FRAMES)
    ) u_order (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_addr),
        .o_rdata (rd_data)
    );

    assign fid_ok  = ({1'b0, r_fid} < (FID_W + 1)'(FRAMES));
    assign fid_idx = IDX_W'(r_fid);
    assign trk     = r_tracked[fid_idx];
    assign ev      = r_evict[fid_idx];

    // victim looks for the oldest evictable entry, pin for its own frame
    assign match = (r_cmd == CMD_VICTIM) ? r_evict[rd_data] : (rd_data == fid_idx);

    assign o_stat.need_scan = ((r_cmd == CMD_VICTIM) && (r_len != '0)) ||
                              ((r_cmd == CMD_PIN) && fid_ok && trk);
    assign o_stat.scan_last = ((LEN_W'(r_rd_addr) + LEN_W'(1)) == r_len);

    always_comb begin
        n_len     = r_len;
        n_tracked = r_tracked;
        n_evict   = r_evict;
        n_total   = r_total;
        n_vvalid  = 1'b0;
        // entries behind the removed one slide down by one
        ram_we    = r_pend && r_found;
        ram_waddr = r_pend_idx - IDX_W'(1);
        ram_wdata = rd_data;
        if (i_cmd.update) begin
            case (r_cmd)
                CMD_VICTIM: begin
                    if (r_found) begin
                        n_vvalid           = 1'b1;
                        n_tracked[r_vframe] = 1'b0;
                        n_evict[r_vframe]   = 1'b0;
                        n_len              = r_len - LEN_W'(1);
                        if (r_total != '0) begin
                            n_total = r_total - CNT_W'(1);
                        end
                    end
                end
                CMD_PIN: begin
                    if (fid_ok) begin
                        if (trk) begin
                            if (ev) begin
                                n_evict[fid_idx] = 1'b0;
                                if (r_total != '0) begin
                                    n_total = r_total - CNT_W'(1);
                                end
                            end
                            ram_we    = 1'b1;
                            ram_waddr = IDX_W'(r_len - LEN_W'(1));
                            ram_wdata = fid_idx;
                        end else begin
                            if (r_len < LEN_W'(FRAMES)) begin
                                ram_we    = 1'b1;
                                ram_waddr = IDX_W'(r_len);
                                ram_wdata = fid_idx;
                                n_len     = r_len + LEN_W'(1);
                            end
                            n_tracked[fid_idx] = 1'b1;
                            n_evict[fid_idx]   = 1'b0;
                        end
                    end
                end
                CMD_UNPIN: begin
                    if (fid_ok) begin
                        if (trk) begin
                            if (!ev) begin
                                n_evict[fid_idx] = 1'b1;
                                n_total          = r_total + CNT_W'(1);
                            end
                        end else if (r_len < i_capacity) begin
                            if (r_len < LEN_W'(FRAMES)) begin
                                ram_we    = 1'b1;
                                ram_waddr = IDX_W'(r_len);
                                ram_wdata = fid_idx;
                                n_len     = r_len + LEN_W'(1);
                            end
                            n_tracked[fid_idx] = 1'b1;
                            n_evict[fid_idx]   = 1'b1;
                            n_total            = r_total + CNT_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_tracked <= '0;
            r_evict   <= '0;
            r_total   <= '0;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
            r_rd_addr <= '0;
        end else begin
            r_len     <= n_len;
            r_tracked <= n_tracked;
            r_evict   <= n_evict;
            r_total   <= n_total;
            r_pend    <= i_cmd.issue_read;
            if (i_cmd.load) begin
                r_found   <= 1'b0;
                r_rd_addr <= '0;
            end else begin
                if (i_cmd.issue_read) begin
                    r_rd_addr <= r_rd_addr + IDX_W'(1);
                end
                if (r_pend && !r_found && match) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_fid <= i_frame_num;
        end
        r_pend_idx <= r_rd_addr;
        if (r_pend && !r_found && match) begin
            r_vframe <= rd_data;
        end
        if (i_cmd.update) begin
            r_o_vvalid <= n_vvalid;
            r_o_vframe <= n_vvalid ? FID_W'(r_vframe) : '0;
            r_o_count  <= n_total;
        end
    end

    assign o_victim_valid    = r_o_vvalid;
    assign o_victim_frame    = r_o_vframe;
    assign o_evictable_count = r_o_count;

endmodule

/* design/lru_frame_replacer_top.sv */
// ============================================================================
// lru_frame_replacer_top
// LRU frame replacer with pinning: recency list of tracked frames, each
// evictable or pinned; victim, pin and unpin commands; evictable count.
// ============================================================================
//
//  Channel   Dir  Handshake                    Payload
//  --------  ---  ---------------------------  ---------------------------------
//  input     in   i_in_valid / o_in_ready      i_command, i_frame_num
//  result    out  o_out_valid / i_out_ready    o_victim_valid, o_victim_frame,
//                                              o_evictable_count
//  config    in   psel/penable/pwrite, pready  paddr, pwdata, prdata
//
//  Sequence: an item that does not walk the list (unpin, pin of an untracked
//  frame, unused command, victim on an empty list) is accepted, decoded and
//  committed; a victim or a pin of a tracked frame also walks the list: the
//  walk reads one recency list entry per cycle through the RAM's single read
//  port, sliding later entries down through its write port.
//  Reset: synchronous, active low; the list is empty, all marks clear, and
//  capacity_limit returns to 64. No clearing pass is needed.
//  Stalls: one item is in flight at a time. A finished result sits in the
//  output register while the next item is accepted and walks the list; the
//  next commit waits only if that result has still not been taken.
//
//  Register map: capacity_limit at byte address 0 (7 bits).
// ============================================================================
module lru_frame_replacer_top
    import lfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input items
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [CMD_W-1:0] i_command,
    input  logic [FID_W-1:0] i_frame_num,
    // result items
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_victim_valid,
    output logic [FID_W-1:0] o_victim_frame,
    output logic [CNT_W-1:0] o_evictable_count,
    // configuration port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_ctl_cmd         ctl_cmd;
    t_dp_stat         dp_stat;
    logic [LEN_W-1:0] r_capacity;
    logic             cfg_wr;
    logic             cap_sel;

    // word 0 holds the only register; word 1 reads as zero
    assign cap_sel = (paddr[2] == 1'b0);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_wr && cap_sel) begin
            r_capacity <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = cap_sel ? {{(32 - LEN_W){1'b0}}, r_capacity} : 32'd0;

    // sequencer
    lfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (ctl_cmd)
    );

    // list memory, marks, counts, result register
    lfr_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (ctl_cmd),
        .o_stat            (dp_stat),
        .i_command         (i_command),
        .i_frame_num       (i_frame_num),
        .i_capacity        (r_capacity),
        .o_victim_valid    (o_victim_valid),
        .o_victim_frame    (o_victim_frame),
        .o_evictable_count (o_evictable_count)
    );

endmodule

/* sim/testbench.sv */
// ============================================================================
// testbench
// Self-checking bench for the LRU frame replacer: a shadow recency list
// predicts victim, victim frame and evictable count for every accepted
// command. Covers directed corner cases, capacity limits, a full list,
// output back-pressure and randomized traffic under several capacity limits.
// ============================================================================
module testbench;
    import lfr_pkg::*;

    // ------------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------------
    localparam int CYCLE_LIMIT  = 1_000_000; // watchdog, far above slowest run
    localparam int HOLD_CYCLES  = 400;       // receiver hold-off for pressure
    localparam int DRAIN_CYCLES = 80;        // > worst item latency
    localparam int PHASE_ITEMS  = 140;       // items per random phase

    localparam logic [CMD_W-1:0] CMD_UNUSED    = 2'd3;
    localparam logic [2:0]       ADDR_CAPACITY = 3'd0;

    // One result item as the block reports it
    typedef struct packed {
        logic             victim_valid;
        logic [FID_W-1:0] victim_frame;
        logic [CNT_W-1:0] evict_count;
    } t_replace_result;

    // ------------------------------------------------------------------------
    // DUT signals; every input known from time zero
    // ------------------------------------------------------------------------
    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [CMD_W-1:0] i_command;
    logic [FID_W-1:0] i_frame_num;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic             o_victim_valid;
    logic [FID_W-1:0] o_victim_frame;
    logic [CNT_W-1:0] o_evictable_count;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    lru_frame_replacer_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_command         (i_command),
        .i_frame_num       (i_frame_num),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_victim_valid    (o_victim_valid),
        .o_victim_frame    (o_victim_frame),
        .o_evictable_count (o_evictable_count),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shadow state of the replacer
    // ------------------------------------------------------------------------
    logic [IDX_W-1:0]  lru_list [FRAMES];  // oldest first
    logic [LEN_W-1:0]  lru_len;
    logic [FRAMES-1:0] is_tracked;
    logic [FRAMES-1:0] is_evictable;
    logic [CNT_W-1:0]  evict_total;
    logic [LEN_W-1:0]  cap_limit;

    t_replace_result results_due [$];      // predicted, not yet seen

    // Run bookkeeping
    int  fail_count     = 0;
    int  items_sent     = 0;
    int  results_seen   = 0;
    int  victims_taken  = 0;
    int  cap_writes     = 0;
    int  cycle_count    = 0;
    bit  gaps_on        = 1'b1;  // random idling on both channels
    int  hold_requests  = 0;     // bumped by a test to ask for a hold-off

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void clear_shadow();
        foreach (lru_list[i]) lru_list[i] = '0;
        lru_len      = '0;
        is_tracked   = '0;
        is_evictable = '0;
        evict_total  = '0;
        cap_limit    = CAP_RESET;
    endfunction

    // Remove list entry at pos, later entries slide toward the old end
    function automatic void drop_entry(input int pos);
        for (int i = pos; i + 1 < lru_len; i++)
            lru_list[i] = lru_list[i + 1];
        if (lru_len != 0)
            lru_len--;
    endfunction

    function automatic void append_frame(input logic [FID_W-1:0] fid);
        if (lru_len < FRAMES) begin
            lru_list[lru_len[IDX_W-1:0]] = fid;
            lru_len++;
        end
    endfunction

    // frame numbers are 6 bits wide and FRAMES is 64, so none is out of range
    function automatic t_replace_result predict_replace(input logic [CMD_W-1:0] cmd,
                                                        input logic [FID_W-1:0] fid);
        t_replace_result r;
        int              pos;
        r   = '0;
        pos = -1;
        case (cmd)
            CMD_VICTIM: begin
                for (int i = 0; i < lru_len; i++)
                    if (pos < 0 && is_evictable[lru_list[i]])
                        pos = i;
                if (pos >= 0) begin
                    r.victim_valid = 1'b1;
                    r.victim_frame = lru_list[pos];
                    is_tracked[lru_list[pos]]   = 1'b0;
                    is_evictable[lru_list[pos]] = 1'b0;
                    drop_entry(pos);
                    if (evict_total != 0)
                        evict_total--;
                    victims_taken++;
                end
            end
            CMD_PIN: begin
                if (is_tracked[fid]) begin
                    if (is_evictable[fid]) begin
                        is_evictable[fid] = 1'b0;
                        if (evict_total != 0)
                            evict_total--;
                    end
                    for (int i = 0; i < lru_len; i++)
                        if (pos < 0 && lru_list[i] == fid)
                            pos = i;
                    if (pos >= 0)
                        drop_entry(pos);
                    append_frame(fid);
                end else begin
                    append_frame(fid);
                    is_tracked[fid]   = 1'b1;
                    is_evictable[fid] = 1'b0;
                end
            end
            CMD_UNPIN: begin
                if (is_tracked[fid]) begin
                    if (!is_evictable[fid]) begin
                        is_evictable[fid] = 1'b1;
                        evict_total++;
                    end
                end else if (lru_len < cap_limit) begin
                    append_frame(fid);
                    is_tracked[fid]   = 1'b1;
                    is_evictable[fid] = 1'b1;
                    evict_total++;
                end
            end
            default: ;  // unused command: state untouched, count reported
        endcase
        r.evict_count = evict_total;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: every accepted result against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_replace_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (results_due.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result item: victim_valid %0d frame %0d count %0d",
                         $time, o_victim_valid, o_victim_frame, o_evictable_count);
            end else begin
                want = results_due.pop_front();
                if (o_victim_valid !== want.victim_valid) begin
                    fail_count++;
                    $display("%0t: victim_valid expected %0d actual %0d",
                             $time, want.victim_valid, o_victim_valid);
                end
                if (o_victim_frame !== want.victim_frame) begin
                    fail_count++;
                    $display("%0t: victim_frame expected %0d actual %0d",
                             $time, want.victim_frame, o_victim_frame);
                end
                if (o_evictable_count !== want.evict_count) begin
                    fail_count++;
                    $display("%0t: evictable_count expected %0d actual %0d",
                             $time, want.evict_count, o_evictable_count);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off when a test asks for one.
    // The hold-off is counted here so the sender keeps pushing meanwhile.
    // ------------------------------------------------------------------------
    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (gaps_on) begin
            i_out_ready <= ($urandom_range(99) >= 17);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: watchdog expired with %0d results outstanding",
                 $time, results_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------------

    // Offer one item, optionally after random idle cycles; valid stays high
    // on return so back-to-back items never drop it within one step.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [FID_W-1:0] fid);
        t_replace_result due;
        while (gaps_on && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_frame_num <= fid;
        do @(posedge i_clk); while (!o_in_ready);
        due = predict_replace(cmd, fid);
        results_due.insert(results_due.size(), due);
        items_sent++;
    endtask

    // Stop offering and wait until every predicted result has been taken.
    // Each item yields exactly one result, so the block is idle afterwards.
    task automatic finish_phase();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_due.size() != 0);
    endtask

    // Write capacity_limit, then read it back (setup/access for each)
    task automatic set_capacity(input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CAPACITY;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cap_limit = LEN_W'(value);
        cap_writes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[LEN_W-1:0] !== cap_limit) begin
            fail_count++;
            $display("%0t: capacity_limit readback expected %0d actual %0d",
                     $time, cap_limit, prdata[LEN_W-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked commands on a small list: empty victim, unused command,
    // extreme frame ids, pin of tracked/untracked, repeated unpin.
    task automatic test_directed();
        send_item(CMD_VICTIM, 6'd0);    // empty list: no victim
        send_item(CMD_UNUSED, 6'd0);
        send_item(CMD_UNPIN,  6'd63);
        send_item(CMD_UNPIN,  6'd0);
        send_item(CMD_PIN,    6'd5);    // untracked -> appended pinned
        send_item(CMD_UNPIN,  6'd63);   // already evictable: no change
        send_item(CMD_PIN,    6'd63);   // evictable -> pinned, moved newest
        send_item(CMD_VICTIM, 6'd63);   // frame id ignored
        send_item(CMD_VICTIM, 6'd0);    // everything left pinned
        send_item(CMD_UNPIN,  6'd5);
        send_item(CMD_PIN,    6'd5);
        send_item(CMD_UNPIN,  6'd63);
        send_item(CMD_UNPIN,  6'd5);
        send_item(CMD_UNUSED, 6'd63);
        send_item(CMD_PIN,    6'd63);   // evictable -> pinned, moved newest
        send_item(CMD_UNPIN,  6'd42);
        send_item(CMD_UNPIN,  6'd21);
        send_item(CMD_VICTIM, 6'd0);
        send_item(CMD_VICTIM, 6'd0);
        send_item(CMD_UNPIN,  6'd63);
        send_item(CMD_VICTIM, 6'd0);
        send_item(CMD_VICTIM, 6'd0);
        send_item(CMD_VICTIM, 6'd0);
        finish_phase();
    endtask

    // Capacity limit: zero blocks every untracked unpin, one allows a single
    // entry, pin ignores the limit in both cases.
    task automatic test_capacity_limit();
        set_capacity(0);
        send_item(CMD_UNPIN,  6'd10);   // blocked
        send_item(CMD_UNPIN,  6'd20);   // blocked
        send_item(CMD_PIN,    6'd10);   // pin still tracks
        send_item(CMD_UNPIN,  6'd10);   // tracked: allowed
        send_item(CMD_VICTIM, 6'd0);
        finish_phase();
        set_capacity(1);
        send_item(CMD_UNPIN,  6'd1);
        send_item(CMD_UNPIN,  6'd2);    // list full
        send_item(CMD_PIN,    6'd3);
        send_item(CMD_UNPIN,  6'd3);
        send_item(CMD_VICTIM, 6'd0);
        send_item(CMD_VICTIM, 6'd0);
        send_item(CMD_VICTIM, 6'd0);
        finish_phase();
        set_capacity(FRAMES);
    endtask

    // Track all 64 frames, pin and release a few, then issue a victim for
    // every frame so victim walks the longest list.
    task automatic test_full_list();
        logic [FID_W-1:0] order [FRAMES];
        logic [FID_W-1:0] tmp;
        int               j;
        foreach (order[i]) order[i] = FID_W'(i);
        for (int i = FRAMES - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[i]) send_item(CMD_UNPIN, order[i]);
        repeat (8) send_item(CMD_PIN, FID_W'($urandom));
        repeat (4) send_item(CMD_UNPIN, FID_W'($urandom));
        repeat (FRAMES) send_item(CMD_VICTIM, FID_W'($urandom));
        finish_phase();
    endtask

    // Receiver holds off for a long stretch while items keep coming
    task automatic test_backpressure();
        hold_requests++;
        for (int n = 0; n < 40; n++)
            send_item(($urandom_range(1) != 0) ? CMD_UNPIN : CMD_PIN, FID_W'($urandom));
        finish_phase();
    endtask

    // Random traffic: most ids from a narrow window so commands hit tracked
    // frames often, the rest anywhere in the id range.
    task automatic run_random_phase(input int count, input int cap);
        int               base;
        int               r;
        logic [CMD_W-1:0] cmd;
        logic [FID_W-1:0] fid;
        finish_phase();
        set_capacity(cap);
        base = $urandom_range(FRAMES - 8);
        for (int n = 0; n < count; n++) begin
            r   = $urandom_range(99);
            cmd = (r < 30) ? CMD_VICTIM : (r < 62) ? CMD_PIN :
                  (r < 96) ? CMD_UNPIN  : CMD_UNUSED;
            fid = ($urandom_range(9) < 6) ? FID_W'(base + $urandom_range(7))
                                          : FID_W'($urandom);
            send_item(cmd, fid);
        end
    endtask

    task automatic test_random();
        run_random_phase(PHASE_ITEMS, FRAMES);
        run_random_phase(PHASE_ITEMS, 0);
        run_random_phase(PHASE_ITEMS, 1);
        run_random_phase(PHASE_ITEMS, 2);
        run_random_phase(PHASE_ITEMS, 17);
        gaps_on = 1'b0;                 // long stretch with no idling
        run_random_phase(PHASE_ITEMS, FRAMES - 1);
        gaps_on = 1'b1;
        run_random_phase(PHASE_ITEMS, $urandom_range(FRAMES));
        run_random_phase(PHASE_ITEMS, FRAMES);
        finish_phase();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_command   = CMD_VICTIM;
        i_frame_num = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = ADDR_CAPACITY;
        pwdata      = '0;
        clear_shadow();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_capacity_limit();
        test_full_list();
        test_backpressure();
        test_random();

        finish_phase();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d commands, checked %0d results (%0d victims) in %0d cycles,",
                 items_sent, results_seen, victims_taken, cycle_count);
        $display("capacity limit written %0d times, %0d mismatches.",
                 cap_writes, fail_count);
        if (fail_count == 0 && results_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* lru_frame_replacer_top.f */
design/lfr_pkg.sv
design/lfr_ram.sv
design/lfr_ctrl.sv
design/lfr_datapath.sv
design/lru_frame_replacer_top.sv
sim/testbench.sv
